// File: hw/rtl/spc_pkg.sv
// Shared types, constants and state encoding for segment_polygon_crossing.
// No dependencies; used by spc_mac and segment_polygon_crossing.
`default_nettype none

package spc_pkg;

  // Coordinate format is fixed by the item fields.
  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;      // coordinate difference
  localparam int PROD_W     = 2 * DIFF_W;          // exact product
  localparam int SUM_W      = PROD_W + 1;          // exact product difference
  localparam int HITS_W     = 11;                  // reported hit count width

  localparam int MAX_EDGES_DEF = 1024;
  localparam int MANY_HITS     = 4;                // this many hits or more: crossing

  localparam int          STEP_W    = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(8);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] query_ax;
    logic signed [COORD_BITS-1:0] query_ay;
    logic signed [COORD_BITS-1:0] query_bx;
    logic signed [COORD_BITS-1:0] query_by;
    logic signed [COORD_BITS-1:0] edge_ax;
    logic signed [COORD_BITS-1:0] edge_ay;
    logic signed [COORD_BITS-1:0] edge_bx;
    logic signed [COORD_BITS-1:0] edge_by;
    logic                         touch_mode;
    logic                         last_edge;
  } edge_item_t;

  typedef struct packed {
    logic              crossing;
    logic [HITS_W-1:0] touch_hits;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_UPDATE
  } state_t;

  // Control of the shared multiply / subtract unit.
  typedef struct packed {
    logic mul;   // load product register
    logic keep;  // move product into first-term register
  } mac_ctl_t;

  // Sign of first-term minus product.
  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

endpackage

`default_nettype wire

// File: hw/rtl/spc_mac.sv
// Shared 17x17 signed multiplier with product difference and sign output.
// Depends on spc_pkg.
`default_nettype none

module spc_mac (
  input  wire logic                             clk,
  input  wire spc_pkg::mac_ctl_t                ctl,
  input  wire logic signed [spc_pkg::DIFF_W-1:0] a,
  input  wire logic signed [spc_pkg::DIFF_W-1:0] b,
  output spc_pkg::sign_t                        sgn
);
  import spc_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] mreg;
  logic signed [PROD_W-1:0] first;
  logic signed [SUM_W-1:0]  diff;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      mreg <= prod;
    end
    if (ctl.keep) begin
      first <= mreg;
    end
  end

  // cross = first - second product
  assign diff     = SUM_W'(first) - SUM_W'(mreg);
  assign sgn.neg  = diff[SUM_W-1];
  assign sgn.zero = (diff == '0);

endmodule

`default_nettype wire

// File: hw/rtl/segment_polygon_crossing.sv
// Top level of segment_polygon_crossing: sequencer, hit counting, result register.
// Depends on spc_pkg and spc_mac.
//
//  channel | valid         | stall         | payload              | direction
//  --------+---------------+---------------+----------------------+----------
//  edge    | edge_valid    | edge_stall    | edge_data (edge_item_t) | into block
//  result  | result_valid  | result_stall  | result_data (result_t)  | out of block
//
// Each edge item is accepted, then runs on the shared 17x17 multiplier
//   (eight products of the four turn tests, one drain step), then updates.
// The multiplier is the block's only multiplier; it sets the item time.
// Reset clears the sequencer, hit count, strict flag and result valid.
// A last edge waits in update while the result register is still full and stalled.
// edge_stall is high from acceptance until the update finishes.
`default_nettype none

module segment_polygon_crossing #(
  parameter int MAX_EDGES = spc_pkg::MAX_EDGES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                edge_valid,
  output logic                     edge_stall,
  input  wire spc_pkg::edge_item_t edge_data,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output spc_pkg::result_t         result_data
);
  import spc_pkg::*;

  localparam int CNT_W = $clog2(MAX_EDGES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_EDGES);

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  edge_item_t        cur;
  logic [CNT_W-1:0]  hit_count;
  logic              strict_seen;
  logic [3:0]        turn_neg;
  logic [3:0]        turn_zero;

  mac_ctl_t          ctl;
  sign_t             sgn;
  logic              accept;
  logic              eval;
  logic              commit;
  logic              out_free;
  logic [1:0]        op_turn;
  logic [1:0]        eval_turn;

  // turn(P, Q, R) operands
  logic signed [DIFF_W-1:0] px, py, qx, qy, rx, ry;
  logic signed [DIFF_W-1:0] op_a, op_b;

  logic             p1_le0, p1_lt0, p2_le0, p2_lt0;
  logic             touch_hit, strict_hit;
  logic [CNT_W-1:0] hit_next;
  logic             strict_next;
  logic             crossing;

  assign accept    = edge_valid && !edge_stall;
  assign out_free  = !result_valid || !result_stall;
  assign op_turn   = step[2:1];
  assign eval_turn = 2'(step[3:1] - 3'd1);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_RUN;
      end
      S_RUN: begin
        if (step == LAST_STEP) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // Even steps multiply (Qx-Px)*(Ry-Qy), odd steps (Qy-Py)*(Rx-Qx).
  // Odd steps park the even product; even steps from 2 on read the turn sign.
  // ---------------------------------------------------------------------------
  always_comb begin
    edge_stall = (state != S_IDLE);
    ctl.mul    = (state == S_RUN) && (step < LAST_STEP);
    ctl.keep   = (state == S_RUN) && step[0];
    eval       = (state == S_RUN) && !step[0] && (step != '0);
    commit     = (state == S_UPDATE) && (!cur.last_edge || out_free);
  end

  // Turn order: edge line vs query B, edge line vs query A,
  // query line vs edge B, query line vs edge A.
  always_comb begin
    if (op_turn[1]) begin
      px = DIFF_W'(cur.query_ax);
      py = DIFF_W'(cur.query_ay);
      qx = DIFF_W'(cur.query_bx);
      qy = DIFF_W'(cur.query_by);
      rx = op_turn[0] ? DIFF_W'(cur.edge_ax) : DIFF_W'(cur.edge_bx);
      ry = op_turn[0] ? DIFF_W'(cur.edge_ay) : DIFF_W'(cur.edge_by);
    end else begin
      px = DIFF_W'(cur.edge_ax);
      py = DIFF_W'(cur.edge_ay);
      qx = DIFF_W'(cur.edge_bx);
      qy = DIFF_W'(cur.edge_by);
      rx = op_turn[0] ? DIFF_W'(cur.query_ax) : DIFF_W'(cur.query_bx);
      ry = op_turn[0] ? DIFF_W'(cur.query_ay) : DIFF_W'(cur.query_by);
    end
    if (step[0]) begin
      op_a = qy - py;
      op_b = rx - qx;
    end else begin
      op_a = qx - px;
      op_b = ry - qy;
    end
  end

  spc_mac u_mac (
    .clk (clk),
    .ctl (ctl),
    .a   (op_a),
    .b   (op_b),
    .sgn (sgn)
  );

  // ---------------------------------------------------------------------------
  // Hit decision from the four turn signs
  // ---------------------------------------------------------------------------
  always_comb begin
    p1_le0 = turn_zero[0] || turn_zero[1] || (turn_neg[0] ^ turn_neg[1]);
    p1_lt0 = !turn_zero[0] && !turn_zero[1] && (turn_neg[0] ^ turn_neg[1]);
    p2_le0 = turn_zero[2] || turn_zero[3] || (turn_neg[2] ^ turn_neg[3]);
    p2_lt0 = !turn_zero[2] && !turn_zero[3] && (turn_neg[2] ^ turn_neg[3]);
    touch_hit  = p1_le0 && p2_le0;
    strict_hit = p1_lt0 && p2_lt0;

    hit_next = hit_count;
    if (touch_hit && (hit_count < CNT_MAX)) begin
      hit_next = hit_count + CNT_W'(1);
    end
    strict_next = strict_seen || strict_hit;

    // touch mode: any hit; else one or many hits cross, two or three need strict
    if (cur.touch_mode) begin
      crossing = (hit_next != '0);
    end else if (hit_next == '0) begin
      crossing = 1'b0;
    end else if ((hit_next == CNT_W'(1)) || (int'(hit_next) >= MANY_HITS)) begin
      crossing = 1'b1;
    end else begin
      crossing = strict_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      hit_count    <= '0;
      strict_seen  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (state == S_RUN) begin
        step <= step + STEP_W'(1);
      end else begin
        step <= '0;
      end

      // a new result may replace one taken at this same edge
      if (commit && cur.last_edge) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      if (commit) begin
        if (cur.last_edge) begin
          hit_count    <= '0;
          strict_seen  <= 1'b0;
        end else begin
          hit_count   <= hit_next;
          strict_seen <= strict_next;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= edge_data;
    end
    if (eval) begin
      turn_neg[eval_turn]  <= sgn.neg;
      turn_zero[eval_turn] <= sgn.zero;
    end
    if (commit && cur.last_edge) begin
      result_data.crossing   <= crossing;
      result_data.touch_hits <= HITS_W'(hit_next);
    end
  end

`ifndef SYNTHESIS
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> edge_stall)
    else $error("edge_stall low right after an accepted item");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_UPDATE) && $past(cur.last_edge))
    else $error("result raised outside the update of a last edge");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(hit_count) <= MAX_EDGES)
    else $error("hit count above edge limit");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (step <= LAST_STEP))
    else $error("sequencer step out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("stalled result lost or changed");
`endif

endmodule

`default_nettype wire
